// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on clk, quiet in reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: rtl/sbp_pkg.sv
// ----------------------------------------------------------------------------
// sbp_pkg
// Types and constants of the six-button pad protocol core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbp_pkg;

	localparam int SELECT_BIT = 6;
	localparam int PHASE_W    = 4;
	localparam int BTN_W      = 12;

	localparam logic [PHASE_W-1:0] PHASE_LAST  = 4'd9;
	localparam logic [PHASE_W-1:0] PHASE_FIRST = 4'd1;

	localparam logic [7:0] DATA_IDLE  = 8'h3F;
	localparam logic [7:0] DATA_NONE  = 8'hFF;

	// button bit positions in the pressed mask
	localparam int BTN_R    = 0;
	localparam int BTN_L    = 1;
	localparam int BTN_D    = 2;
	localparam int BTN_U    = 3;
	localparam int BTN_A    = 4;
	localparam int BTN_B    = 5;
	localparam int BTN_C    = 6;
	localparam int BTN_ST   = 7;
	localparam int BTN_X    = 8;
	localparam int BTN_Y    = 9;
	localparam int BTN_Z    = 10;
	localparam int BTN_MODE = 11;

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef struct packed {
		logic       en;
		logic       port;
		logic [7:0] value;
	} wr_req_t;

	typedef struct packed {
		logic [7:0]         ctrl;
		logic [PHASE_W-1:0] phase;
	} port_view_t;

endpackage

// File: rtl/sbp_ifs.sv
// ----------------------------------------------------------------------------
// sbp_ifs
// Request and response channels, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sbp_req_if;
	import sbp_pkg::*;
	logic             valid;
	logic             ready;
	logic             operation;
	logic             port;
	logic [7:0]       value;
	logic [BTN_W-1:0] buttons;

	modport source (output valid, operation, port, value, buttons, input ready);
	modport sink   (input valid, operation, port, value, buttons, output ready);
endinterface

interface sbp_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;

	modport source (output valid, read_data, input ready);
	modport sink   (input valid, read_data, output ready);
endinterface

// File: rtl/sbp_port_state.sv
// ----------------------------------------------------------------------------
// sbp_port_state
// Per-port control byte and phase counter, with TH edge detection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbp_port_state (
	input  logic                clk,
	input  logic                arst_n,
	input  sbp_pkg::wr_req_t    wr,
	input  logic                sel_port,
	output sbp_pkg::port_view_t view
);
	import sbp_pkg::*;

	logic [7:0]         ctrl_q  [2];
	logic [PHASE_W-1:0] phase_q [2];
	logic               th_change;
	logic [PHASE_W-1:0] phase_next;

	assign th_change  = ctrl_q[wr.port][SELECT_BIT] != wr.value[SELECT_BIT];
	assign phase_next = (phase_q[wr.port] >= PHASE_LAST) ? PHASE_FIRST
	                                                     : phase_q[wr.port] + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q[0]  <= '0;
			ctrl_q[1]  <= '0;
			phase_q[0] <= '0;
			phase_q[1] <= '0;
		end else if (wr.en) begin
			ctrl_q[wr.port] <= wr.value;
			if (th_change) begin
				phase_q[wr.port] <= phase_next;
			end
		end
	end

	assign view.ctrl  = ctrl_q[sel_port];
	assign view.phase = phase_q[sel_port];

endmodule

// File: rtl/sbp_read_mux.sv
// ----------------------------------------------------------------------------
// sbp_read_mux
// Data byte selection by phase and TH level, active-low buttons.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbp_read_mux (
	input  sbp_pkg::port_view_t      view,
	input  logic [sbp_pkg::BTN_W-1:0] buttons,
	output logic [7:0]               read_data
);
	import sbp_pkg::*;

	logic       th;
	logic [5:0] grp_bc;
	logic [5:0] grp_as;
	logic [3:0] grp_xyz;

	assign th = view.ctrl[SELECT_BIT];

	assign grp_bc  = {buttons[BTN_C], buttons[BTN_B], buttons[BTN_R],
	                  buttons[BTN_L], buttons[BTN_D], buttons[BTN_U]};
	assign grp_as  = {buttons[BTN_ST], buttons[BTN_A], buttons[BTN_R],
	                  buttons[BTN_L], buttons[BTN_D], buttons[BTN_U]};
	assign grp_xyz = {buttons[BTN_MODE], buttons[BTN_Z], buttons[BTN_Y], buttons[BTN_X]};

	always_comb begin
		read_data = DATA_NONE;
		case (view.phase)
			4'd0: begin
				read_data = DATA_IDLE;
			end
			4'd1, 4'd3, 4'd5: begin
				if (th) begin
					read_data = {2'b11, ~grp_bc};
				end
			end
			4'd2, 4'd4, 4'd6, 4'd8: begin
				if (!th) begin
					read_data = {2'b11, ~grp_as};
				end
			end
			4'd7, 4'd9: begin
				if (th) begin
					read_data = {4'b0000, ~grp_xyz};
				end
			end
			default: begin
				read_data = DATA_NONE;
			end
		endcase
	end

endmodule

// File: rtl/six_button_pad_protocol_core.sv
// ----------------------------------------------------------------------------
// six_button_pad_protocol_core
// A read is registered in stage 1; its data byte is then registered in the response register.
// Throughput: 1 transaction per cycle, unless a read in stage 1 waits on a held response.
// Writes update the port state in the first stage and give no response.
// Reset (arst_n, async, low): control bytes and phases to zero, pipeline empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module six_button_pad_protocol_core (
	input  logic    clk,
	input  logic    arst_n,
	sbp_req_if.sink  req,
	sbp_rsp_if.source rsp
);
	import sbp_pkg::*;

	logic             valid_s1;
	op_t              op_s1;
	logic             port_s1;
	logic [7:0]       value_s1;
	logic [BTN_W-1:0] buttons_s1;

	logic             rsp_valid_q;
	logic [7:0]       read_data_q;

	logic             adv;
	logic             adv_read;
	logic             req_acc;
	wr_req_t          wr;
	port_view_t       view;
	logic [7:0]       read_data;

	assign adv      = valid_s1 && (op_s1 == OP_WRITE || !rsp_valid_q || rsp.ready);
	assign adv_read = adv && op_s1 == OP_READ;
	assign req.ready = !valid_s1 || adv;
	assign req_acc  = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_s1      <= op_t'(req.operation);
			port_s1    <= req.port;
			value_s1   <= req.value;
			buttons_s1 <= req.buttons;
		end
	end

	assign wr.en    = adv && op_s1 == OP_WRITE;
	assign wr.port  = port_s1;
	assign wr.value = value_s1;

	sbp_port_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.sel_port (port_s1),
		.view     (view)
	);

	sbp_read_mux u_mux (
		.view      (view),
		.buttons   (buttons_s1),
		.read_data (read_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_read) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_read) begin
			read_data_q <= read_data;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = read_data_q;

	`ASSERT_CLK(a_rsp_from_read, $rose(rsp_valid_q) |-> $past(adv_read), "response without read")
	`ASSERT_NEVER(a_phase_range, valid_s1 && view.phase > PHASE_LAST, "phase out of range")
	`ASSERT_CLK(a_s1_hold, (valid_s1 && !adv) |=> (valid_s1 && $stable(port_s1) && $stable(op_s1)), "stage 1 lost")

endmodule

// File: bench/six_button_pad_protocol_checker.sv
// ----------------------------------------------------------------------------
// six_button_pad_protocol_checker
// Watches the request and response channels of the pad protocol core. It
// keeps its own copy of the per-port control bytes and phase counters,
// predicts the data byte of every accepted read transaction and compares it
// in order with the responses that come back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module six_button_pad_protocol_checker (
	input  logic       clk,
	input  logic       arst_n,
	sbp_req_if         req,
	sbp_rsp_if         rsp,
	output int         errors,
	output int         outstanding,
	output int         reads_seen,
	output int         writes_seen,
	output logic [9:0] phases_read,
	output int         unmatched_reads
);
	import sbp_pkg::*;

	localparam logic [7:0] NIBBLE_MASK  = 8'h0F;
	localparam int         REPORT_LIMIT = 10;

	logic [7:0]         ctrl_copy  [2];
	logic [PHASE_W-1:0] phase_copy [2];
	logic [7:0]         pending_bytes [$];
	int                 err_count;
	int                 rd_count;
	int                 wr_count;
	int                 unmatched_count;
	logic [9:0]         phase_hits;

	// active-low byte for the given phase and select level
	function automatic logic [7:0] pad_byte(input logic [PHASE_W-1:0] ph, input logic th,
			input logic [BTN_W-1:0] b, output logic matched);
		logic [3:0] dpad;
		dpad    = {b[BTN_R], b[BTN_L], b[BTN_D], b[BTN_U]};
		matched = 1'b1;
		case (ph)
			4'd0: return DATA_IDLE;
			4'd1, 4'd3, 4'd5: if (th) return ~{2'b00, b[BTN_C], b[BTN_B], dpad};
			4'd2, 4'd4, 4'd6, 4'd8: if (!th) return ~{2'b00, b[BTN_ST], b[BTN_A], dpad};
			4'd7, 4'd9: if (th)
				return NIBBLE_MASK & ~{4'h0, b[BTN_MODE], b[BTN_Z], b[BTN_Y], b[BTN_X]};
			default: ;
		endcase
		matched = 1'b0;
		return DATA_NONE;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		logic [7:0] want;
		logic [7:0] got;
		logic       hit;
		if (!arst_n) begin
			ctrl_copy[0]    = '0;
			ctrl_copy[1]    = '0;
			phase_copy[0]   = '0;
			phase_copy[1]   = '0;
			pending_bytes.delete();
			err_count       = 0;
			rd_count        = 0;
			wr_count        = 0;
			unmatched_count = 0;
			phase_hits      = '0;
		end else begin
			// response first, so a stray one is never matched with this edge's read
			if (rsp.valid && rsp.ready) begin
				got = rsp.read_data;
				if (pending_bytes.size() == 0) begin
					err_count++;
					if (err_count <= REPORT_LIMIT)
						$display("[%0t] read_data %02h with no read outstanding", $time, got);
				end else begin
					want = pending_bytes.pop_front();
					if (got !== want) begin
						err_count++;
						if (err_count <= REPORT_LIMIT)
							$display("[%0t] read_data mismatch: expected %02h, got %02h",
								$time, want, got);
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.operation == OP_WRITE) begin
					if (ctrl_copy[req.port][SELECT_BIT] != req.value[SELECT_BIT])
						phase_copy[req.port] = (phase_copy[req.port] >= PHASE_LAST) ?
							PHASE_FIRST : phase_copy[req.port] + 1'b1;
					ctrl_copy[req.port] = req.value;
					wr_count++;
				end else begin
					want = pad_byte(phase_copy[req.port], ctrl_copy[req.port][SELECT_BIT],
						req.buttons, hit);
					pending_bytes.push_back(want);
					phase_hits[phase_copy[req.port]] = 1'b1;
					if (!hit)
						unmatched_count++;
					rd_count++;
				end
			end
		end
		errors          <= err_count;
		outstanding     <= pending_bytes.size();
		reads_seen      <= rd_count;
		writes_seen     <= wr_count;
		phases_read     <= phase_hits;
		unmatched_reads <= unmatched_count;
	end

endmodule

// File: bench/six_button_pad_protocol_core_test.sv
// ----------------------------------------------------------------------------
// six_button_pad_protocol_core_test
// Drives control writes and data reads into the pad protocol core under
// three idling mixes, a long response stall and two full drains, and leaves
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module six_button_pad_protocol_core_test;
	import sbp_pkg::*;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int ITEMS_PER_MIX  = 460;
	localparam int HOLD_CYCLES    = 90;
	localparam int DRAIN_CYCLES   = 10;

	logic       clk;
	logic       arst_n;
	int         tx_idle_pct;
	int         rx_idle_pct;
	int         hold_request;
	int         cycle_count;
	logic [7:0] ctrl_written [2];

	int         errors;
	int         outstanding;
	int         reads_seen;
	int         writes_seen;
	logic [9:0] phases_read;
	int         unmatched_reads;

	sbp_req_if req_ch ();
	sbp_rsp_if rsp_ch ();

	six_button_pad_protocol_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	six_button_pad_protocol_checker pad_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_ch),
		.rsp             (rsp_ch),
		.errors          (errors),
		.outstanding     (outstanding),
		.reads_seen      (reads_seen),
		.writes_seen     (writes_seen),
		.phases_read     (phases_read),
		.unmatched_reads (unmatched_reads)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("six_button_pad_protocol_core_test failed");
		$finish;
	end

	// response side: random back-pressure, plus one long hold on request
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_request = 0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic offer(input op_t op, input logic p, input logic [7:0] v,
			input logic [BTN_W-1:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.port      <= p;
		req_ch.value     <= v;
		req_ch.buttons   <= b;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic write_ctrl(input logic p, input logic [7:0] v);
		ctrl_written[p] = v;
		offer(OP_WRITE, p, v, BTN_W'($urandom_range(4095)));
	endtask

	task automatic random_accesses(input int count);
		logic       p;
		logic [7:0] v;
		for (int i = 0; i < count; i++) begin
			p = 1'($urandom_range(1));
			v = 8'($urandom_range(255));
			if ($urandom_range(99) < 40) begin
				// mostly toggle the select bit so the phase walks through its cycle
				if ($urandom_range(99) < 80)
					v[SELECT_BIT] = ~ctrl_written[p][SELECT_BIT];
				else
					v[SELECT_BIT] = ctrl_written[p][SELECT_BIT];
				write_ctrl(p, v);
			end else begin
				offer(OP_READ, p, v, BTN_W'($urandom_range(4095)));
			end
		end
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		logic [BTN_W-1:0] pattern;
		hold_request     = 0;
		tx_idle_pct      = 26;
		rx_idle_pct      = 53;
		ctrl_written[0]  = '0;
		ctrl_written[1]  = '0;
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.operation <= OP_READ;
		req_ch.port      <= 1'b0;
		req_ch.value     <= '0;
		req_ch.buttons   <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle phase on both ports, then a write that leaves select unchanged
		offer(OP_READ, 1'b0, 8'h00, '1);
		offer(OP_READ, 1'b1, 8'hFF, '0);
		write_ctrl(1'b1, 8'hBF);
		offer(OP_READ, 1'b1, 8'h00, 12'hAAA);
		// full phase walk on port 0, ending in the wrap where select no longer matches
		for (int k = 0; k < 10; k++) begin
			case (k % 4)
				0: pattern = '1;
				1: pattern = '0;
				2: pattern = 12'h555;
				default: pattern = 12'hAAA;
			endcase
			write_ctrl(1'b0, ctrl_written[0] ^ (8'h01 << SELECT_BIT));
			offer(OP_READ, 1'b0, 8'h00, pattern);
		end

		random_accesses(ITEMS_PER_MIX);
		drain();

		tx_idle_pct = 53;
		rx_idle_pct = 26;
		random_accesses(ITEMS_PER_MIX);

		tx_idle_pct  = 0;
		rx_idle_pct  = 0;
		hold_request = 1;
		random_accesses(ITEMS_PER_MIX);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d data reads and %0d control writes on both ports, %s",
			reads_seen, writes_seen, "three idling mixes, one long stall and a drain.");
		$display("Phases read (one bit per phase): %b; %0d reads hit a select mismatch.",
			phases_read, unmatched_reads);
		if (errors == 0 && outstanding == 0) begin
			$display("six_button_pad_protocol_core_test passed");
		end else begin
			$display("six_button_pad_protocol_core_test failed");
		end
		$finish;
	end

endmodule
